>>> rtl/core/tcg_pkg.sv
// shared types and constants for the triangle coverage grid
`timescale 1ns / 1ps
package tcg_pkg;
    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_TRI   = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;
    localparam logic [1:0] FUNC_NOP   = 2'd3;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // edge setup values: coefficients and constant of one half-space edge
    typedef struct packed {
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic signed [34:0] c;
    } t_edge;

    // one classified operation as it sits in the queue
    typedef struct packed {
        logic [1:0]  func;
        logic        fill_value;
        logic [11:0] cell_col;
        logic [11:0] cell_row;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic signed [15:0] x2;
        logic signed [15:0] y2;
        logic signed [15:0] x3;
        logic signed [15:0] y3;
    } t_op;
endpackage

>>> rtl/core/triangle_coverage_grid.sv
// top level of the triangle coverage grid
// a clear sweeps the full store, a triangle scans the used width*height cells,
// a query reads one cell and reports its result
// the back end runs one operation at a time while the queue holds the next ones
// reset: synchronous active low, then a clearing pass over all MAX_WIDTH*MAX_HEIGHT
// cells; the queue takes up to two beats meanwhile; the receiver cannot stall
`timescale 1ns / 1ps
module triangle_coverage_grid
    import tcg_pkg::*;
#(
    parameter int MAX_WIDTH     = 256,
    parameter int MAX_HEIGHT    = 256,
    parameter int SUBPIXEL_BITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic signed [15:0] i_vx_a,
    input  logic signed [15:0] i_vy_a,
    input  logic signed [15:0] i_vx_b,
    input  logic signed [15:0] i_vy_b,
    input  logic signed [15:0] i_vx_c,
    input  logic signed [15:0] i_vy_c,
    input  logic        i_fill_value,
    input  logic [11:0] i_cell_col,
    input  logic [11:0] i_cell_row,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    output logic        o_strobe,
    output logic        o_is_road,
    output logic        o_out_of_range,
    output logic [1:0]  o_op_done
);
    logic [8:0] r_width, r_height;
    t_op  w_in, w_q;
    logic w_full, w_empty, w_pop, w_bbusy;

    // config only taken while nothing is queued or running
    assign o_cfg_ready = w_empty && !w_bbusy && !start;
    assign busy = w_full;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 9'd256;
            r_height <= 9'd256;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_WIDTH) r_width <= i_cfg_data;
            if (i_cfg_index == CFG_HEIGHT) r_height <= i_cfg_data;
        end
    end

    always_comb begin
        w_in.func       = i_func;
        w_in.fill_value = i_fill_value;
        w_in.cell_col   = i_cell_col;
        w_in.cell_row   = i_cell_row;
        w_in.x1 = i_vx_a; w_in.y1 = i_vy_a;
        w_in.x2 = i_vx_b; w_in.y2 = i_vy_b;
        w_in.x3 = i_vx_c; w_in.y3 = i_vy_c;
    end

    tcg_front #(.DEPTH(2)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(start), .i_op(w_in), .o_full(w_full),
        .i_pop(w_pop), .o_empty(w_empty), .o_op(w_q)
    );

    tcg_back #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .SUBPIXEL_BITS(SUBPIXEL_BITS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_width(r_width), .i_height(r_height),
        .i_empty(w_empty), .i_op(w_q), .o_pop(w_pop), .o_busy(w_bbusy),
        .o_valid(o_strobe), .o_is_road(o_is_road),
        .o_out_of_range(o_out_of_range), .o_op_done(o_op_done)
    );
endmodule

>>> rtl/core/tcg_front.sv
// front end: accepts operations and pushes them into a small queue
`timescale 1ns / 1ps
module tcg_front
    import tcg_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_op  o_op
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_op            r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_op    = r_mem[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_op;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push && !o_full) - (AW+1)'(i_pop && !o_empty);
        end
    end
endmodule

>>> rtl/core/tcg_back.sv
// back end: clears, rasterizes and queries the coverage memory
`timescale 1ns / 1ps
module tcg_back
    import tcg_pkg::*;
#(
    parameter int MAX_WIDTH     = 256,
    parameter int MAX_HEIGHT    = 256,
    parameter int SUBPIXEL_BITS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [8:0] i_width,
    input  logic [8:0] i_height,
    input  logic       i_empty,
    input  t_op        i_op,
    output logic       o_pop,
    output logic       o_busy,
    output logic       o_valid,
    output logic       o_is_road,
    output logic       o_out_of_range,
    output logic [1:0] o_op_done
);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = CW + RW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INIT  = 3'd1;
    localparam logic [2:0] S_CLEAR = 3'd2;
    localparam logic [2:0] S_SETUP = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_QRY   = 3'd5;
    localparam logic [2:0] S_QRY2  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic          r_mem [DEPTH];
    logic [2:0]    r_state;
    logic [CW:0]   r_col;
    logic [RW:0]   r_row;
    logic [12:0]   r_w, r_h;
    t_op           r_op;
    t_edge         r_e1, r_e2, r_e3;
    // edge values at the current cell, stepped incrementally
    logic signed [47:0] r_v1, r_v2, r_v3;
    logic signed [47:0] r_r1, r_r2, r_r3;
    logic          r_rd;
    logic          r_oor;

    logic [12:0] w_used, h_used;
    assign w_used = (13'(i_width)  > 13'(MAX_WIDTH))  ? 13'(MAX_WIDTH)  : 13'(i_width);
    assign h_used = (13'(i_height) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(i_height);

    function automatic t_edge mk_edge(logic signed [15:0] xa, logic signed [15:0] ya,
                                      logic signed [15:0] xb, logic signed [15:0] yb);
        t_edge e;
        e.dx = 17'(xa) - 17'(xb);
        e.dy = 17'(ya) - 17'(yb);
        e.c  = 35'(e.dy * xa) - 35'(e.dx * ya);
        if (e.dy < 0 || (e.dy == 0 && e.dx > 0)) begin
            e.c = e.c + 35'sd1;
        end
        return e;
    endfunction

    logic [AW-1:0] w_addr;
    assign w_addr = {r_row[RW-1:0], r_col[CW-1:0]};

    logic w_hit;
    assign w_hit = (r_v1 > 0) && (r_v2 > 0) && (r_v3 > 0);

    logic w_qin;
    assign w_qin = (13'(r_op.cell_col) < r_w) && (13'(r_op.cell_row) < r_h);

    logic w_last_col, w_last_row;
    assign w_last_col = (13'(r_col) + 13'd1 >= r_w);
    assign w_last_row = (13'(r_row) + 13'd1 >= r_h);

    assign o_busy = (r_state != S_IDLE);
    assign o_pop  = (r_state == S_IDLE) && !i_empty;

    // coverage memory, one port
    always_ff @(posedge i_clk) begin
        if (r_state == S_INIT || r_state == S_CLEAR) begin
            r_mem[w_addr] <= 1'b0;
        end else if (r_state == S_SCAN && w_hit && r_w != 0 && r_h != 0) begin
            r_mem[w_addr] <= r_op.fill_value;
        end
        r_rd <= r_mem[{r_op.cell_row[RW-1:0], r_op.cell_col[CW-1:0]}];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_col   <= '0;
            r_row   <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_op  <= i_op;
                        r_w   <= w_used;
                        r_h   <= h_used;
                        r_col <= '0;
                        r_row <= '0;
                        case (i_op.func)
                            FUNC_CLEAR: r_state <= S_CLEAR;
                            FUNC_TRI:   r_state <= S_SETUP;
                            FUNC_QUERY: r_state <= S_QRY;
                            default:    r_state <= S_DONE;
                        endcase
                    end
                end
                S_INIT, S_CLEAR: begin
                    if (r_col == (CW+1)'(MAX_WIDTH-1)) begin
                        r_col <= '0;
                        if (r_row == (RW+1)'(MAX_HEIGHT-1)) begin
                            r_row   <= '0;
                            r_state <= (r_state == S_INIT) ? S_IDLE : S_DONE;
                        end else begin
                            r_row <= r_row + 1'b1;
                        end
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                S_SETUP: begin
                    r_e1 <= mk_edge(r_op.x1, r_op.y1, r_op.x2, r_op.y2);
                    r_e2 <= mk_edge(r_op.x2, r_op.y2, r_op.x3, r_op.y3);
                    r_e3 <= mk_edge(r_op.x3, r_op.y3, r_op.x1, r_op.y1);
                    r_state <= S_QRY2;
                end
                S_QRY2: begin
                    // second setup step (triangles) or read data ready (queries)
                    if (r_op.func == FUNC_TRI) begin
                        r_v1 <= 48'(r_e1.c); r_r1 <= 48'(r_e1.c);
                        r_v2 <= 48'(r_e2.c); r_r2 <= 48'(r_e2.c);
                        r_v3 <= 48'(r_e3.c); r_r3 <= 48'(r_e3.c);
                        r_state <= (r_w == 0 || r_h == 0) ? S_DONE : S_SCAN;
                    end else begin
                        r_oor   <= !w_qin;
                        r_state <= S_DONE;
                    end
                end
                S_SCAN: begin
                    if (w_last_col) begin
                        r_col <= '0;
                        if (w_last_row) begin
                            r_state <= S_DONE;
                        end else begin
                            r_row <= r_row + 1'b1;
                            r_r1 <= r_r1 + 48'(r_e1.dx <<< SUBPIXEL_BITS);
                            r_r2 <= r_r2 + 48'(r_e2.dx <<< SUBPIXEL_BITS);
                            r_r3 <= r_r3 + 48'(r_e3.dx <<< SUBPIXEL_BITS);
                            r_v1 <= r_r1 + 48'(r_e1.dx <<< SUBPIXEL_BITS);
                            r_v2 <= r_r2 + 48'(r_e2.dx <<< SUBPIXEL_BITS);
                            r_v3 <= r_r3 + 48'(r_e3.dx <<< SUBPIXEL_BITS);
                        end
                    end else begin
                        r_col <= r_col + 1'b1;
                        r_v1 <= r_v1 - 48'(r_e1.dy <<< SUBPIXEL_BITS);
                        r_v2 <= r_v2 - 48'(r_e2.dy <<< SUBPIXEL_BITS);
                        r_v3 <= r_v3 - 48'(r_e3.dy <<< SUBPIXEL_BITS);
                    end
                end
                S_QRY: begin
                    // memory read issued this cycle
                    r_state <= S_QRY2;
                end
                S_DONE: begin
                    o_valid        <= 1'b1;
                    o_op_done      <= r_op.func;
                    o_is_road      <= (r_op.func == FUNC_QUERY) && !r_oor && r_rd;
                    o_out_of_range <= (r_op.func == FUNC_QUERY) && r_oor;
                    r_state        <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/core/tcg_checker.sv
// port-level checks for the triangle coverage grid
`timescale 1ns / 1ps
module tcg_checker
    import tcg_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_strobe,
    input logic       o_is_road,
    input logic       o_out_of_range,
    input logic [1:0] o_op_done
);
    // only a query reports road or out of range
    a_road_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_is_road || o_out_of_range) |-> o_op_done == FUNC_QUERY)
        else $error("road flag on non-query");
    // road and out of range never together
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_is_road && o_out_of_range))
        else $error("road and out of range both set");
    // results are single-cycle beats
    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("strobe held");
endmodule

bind triangle_coverage_grid tcg_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .o_strobe(o_strobe), .o_is_road(o_is_road),
    .o_out_of_range(o_out_of_range), .o_op_done(o_op_done)
);

>>> tb/triangle_coverage_grid_test.sv
// testbench for the triangle coverage grid: directed table, random ops, grid predictor
`timescale 1ns / 1ps
module triangle_coverage_grid_test;
    import tcg_pkg::*;

    localparam int GRID_MAX    = 256;
    localparam int SUB_BITS    = 4;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int RAND_PHASES = 7;
    localparam int PHASE_ITEMS = 115;

    typedef struct {
        logic [1:0] func;
        logic signed [15:0] xa, ya, xb, yb, xc, yc;
        logic       fill;
        logic [11:0] col, row;
    } op_t;

    typedef struct {
        logic       road;
        logic       oor;
        logic [1:0] op;
    } answer_t;

    typedef struct {
        op_t     op;
        bit      typed;
        answer_t ans;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_func = FUNC_NOP;
    logic signed [15:0] i_vx_a = '0, i_vy_a = '0, i_vx_b = '0;
    logic signed [15:0] i_vy_b = '0, i_vx_c = '0, i_vy_c = '0;
    logic        i_fill_value = 1'b0;
    logic [11:0] i_cell_col = '0;
    logic [11:0] i_cell_row = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_WIDTH;
    logic [8:0]  i_cfg_data = '0;
    logic        o_strobe;
    logic        o_is_road;
    logic        o_out_of_range;
    logic [1:0]  o_op_done;

    triangle_coverage_grid dut (.*);

    always #6 i_clk = ~i_clk;

    // predictor state
    bit      cover_map [0:GRID_MAX*GRID_MAX-1];
    int      cfg_w = 256;
    int      cfg_h = 256;
    answer_t pending_answers[$];
    int      fail_count = 0;
    int      cycle_count = 0;
    stim_row_t directed_rows[$];

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("triangle_coverage_grid test failed");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        answer_t want;
        if (i_rst_n && o_strobe) begin
            if (pending_answers.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end else begin
                want = pending_answers.pop_front();
                if (o_is_road !== want.road) begin
                    $error("is_road expected %0d actual %0d", want.road, o_is_road);
                    fail_count++;
                end
                if (o_out_of_range !== want.oor) begin
                    $error("out_of_range expected %0d actual %0d", want.oor, o_out_of_range);
                    fail_count++;
                end
                if (o_op_done !== want.op) begin
                    $error("op_done expected %0d actual %0d", want.op, o_op_done);
                    fail_count++;
                end
            end
        end
    end

    function automatic longint edge_bias(longint x1, longint y1, longint dx, longint dy);
        longint c;
        c = dy * x1 - dx * y1;
        if (dy < 0 || (dy == 0 && dx > 0)) c += 1;
        return c;
    endfunction

    // apply one op to the grid copy and return its answer
    function automatic answer_t grid_step(op_t o);
        answer_t a;
        longint x1, y1, x2, y2, x3, y3, dx12, dx23, dx31, dy12, dy23, dy31;
        longint c1, c2, c3, sx, sy;
        int w, h;
        w = (cfg_w > GRID_MAX) ? GRID_MAX : cfg_w;
        h = (cfg_h > GRID_MAX) ? GRID_MAX : cfg_h;
        a.road = 1'b0;
        a.oor  = 1'b0;
        a.op   = o.func;
        case (o.func)
            FUNC_CLEAR: begin
                foreach (cover_map[i]) cover_map[i] = 1'b0;
            end
            FUNC_TRI: begin
                x1 = o.xa; y1 = o.ya; x2 = o.xb; y2 = o.yb; x3 = o.xc; y3 = o.yc;
                dx12 = x1 - x2; dx23 = x2 - x3; dx31 = x3 - x1;
                dy12 = y1 - y2; dy23 = y2 - y3; dy31 = y3 - y1;
                c1 = edge_bias(x1, y1, dx12, dy12);
                c2 = edge_bias(x2, y2, dx23, dy23);
                c3 = edge_bias(x3, y3, dx31, dy31);
                for (int r = 0; r < h; r++) begin
                    sy = longint'(r) << SUB_BITS;
                    for (int c = 0; c < w; c++) begin
                        sx = longint'(c) << SUB_BITS;
                        if (c1 + dx12 * sy - dy12 * sx > 0 &&
                            c2 + dx23 * sy - dy23 * sx > 0 &&
                            c3 + dx31 * sy - dy31 * sx > 0)
                            cover_map[r * GRID_MAX + c] = o.fill;
                    end
                end
            end
            FUNC_QUERY: begin
                if (o.col < w && o.row < h) a.road = cover_map[o.row * GRID_MAX + o.col];
                else a.oor = 1'b1;
            end
            default: ;
        endcase
        return a;
    endfunction

    // drive one op and wait for its acceptance beat
    task automatic send_op(op_t o, int gap, bit typed, answer_t typed_ans);
        answer_t a;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_func <= o.func;
        i_vx_a <= o.xa; i_vy_a <= o.ya;
        i_vx_b <= o.xb; i_vy_b <= o.yb;
        i_vx_c <= o.xc; i_vy_c <= o.yc;
        i_fill_value <= o.fill;
        i_cell_col <= o.col;
        i_cell_row <= o.row;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        a = grid_step(o);
        pending_answers.push_back(typed ? typed_ans : a);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // one config beat, then the channel goes idle
    task automatic write_reg(logic idx, logic [8:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_WIDTH) cfg_w = data;
        else cfg_h = data;
        @(posedge i_clk);
    endtask

    function automatic op_t mk_op(logic [1:0] f, int xa, int ya, int xb, int yb,
                                  int xc, int yc, int fill, int col, int row);
        op_t o;
        o.func = f;
        o.xa = 16'(xa); o.ya = 16'(ya); o.xb = 16'(xb);
        o.yb = 16'(yb); o.xc = 16'(xc); o.yc = 16'(yc);
        o.fill = 1'(fill);
        o.col = 12'(col);
        o.row = 12'(row);
        return o;
    endfunction

    task automatic add_row(op_t o, int typed, int road, int oor);
        stim_row_t s;
        s.op = o;
        s.typed = (typed != 0);
        s.ans.road = 1'(road);
        s.ans.oor = 1'(oor);
        s.ans.op = o.func;
        directed_rows.push_back(s);
    endtask

    // vertex coordinate near the grid, now and then anywhere
    function automatic int pick_coord(int span);
        if ($urandom_range(0, 7) == 0) return int'($urandom_range(0, 65535)) - 32768;
        return int'($urandom_range(0, (span + 3) * 16)) - 24;
    endfunction

    function automatic op_t random_op();
        op_t o;
        int sel, w, h;
        w = (cfg_w > GRID_MAX) ? GRID_MAX : cfg_w;
        h = (cfg_h > GRID_MAX) ? GRID_MAX : cfg_h;
        sel = $urandom_range(0, 99);
        o = mk_op(FUNC_NOP, 0, 0, 0, 0, 0, 0, $urandom_range(0, 1),
                  $urandom_range(0, 4095), $urandom_range(0, 4095));
        if (sel < 47) begin
            o.func = FUNC_TRI;
            o.xa = 16'(pick_coord(w)); o.ya = 16'(pick_coord(h));
            o.xb = 16'(pick_coord(w)); o.yb = 16'(pick_coord(h));
            o.xc = 16'(pick_coord(w)); o.yc = 16'(pick_coord(h));
        end else if (sel < 95) begin
            o.func = FUNC_QUERY;
            if ($urandom_range(0, 4) != 0) begin
                o.col = 12'($urandom_range(0, w + 1));
                o.row = 12'($urandom_range(0, h + 1));
            end
        end
        return o;
    endfunction

    initial begin
        int phase_w[RAND_PHASES] = '{16, 0, 511, 1, 24, 7, 256};
        int phase_h[RAND_PHASES] = '{16, 12, 3, 1, 20, 300, 2};
        answer_t none;
        none = '{road: 1'b0, oor: 1'b0, op: FUNC_NOP};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, grid at its reset size
        add_row(mk_op(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0);
        add_row(mk_op(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 4095, 4095), 1, 0, 1);
        add_row(mk_op(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 255, 255), 1, 0, 0);
        add_row(mk_op(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 256, 0), 1, 0, 1);
        add_row(mk_op(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 256), 1, 0, 1);
        add_row(mk_op(FUNC_NOP, 0, 0, 0, 0, 0, 0, 1, 7, 7), 1, 0, 0);
        add_row(mk_op(FUNC_TRI, 0, 0, 800, 0, 0, 800, 1, 0, 0), 0, 0, 0);
        add_row(mk_op(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 2, 2), 0, 0, 0);
        add_row(mk_op(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0);
        add_row(mk_op(FUNC_TRI, 0, 0, 0, 800, 800, 0, 1, 0, 0), 0, 0, 0);
        add_row(mk_op(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 30, 10), 0, 0, 0);
        add_row(mk_op(FUNC_TRI, 16, 16, 160, 160, 320, 320, 1, 0, 0), 0, 0, 0);
        add_row(mk_op(FUNC_TRI, -32768, -32768, 32767, -32768, -32768, 32767, 0, 0, 0),
                0, 0, 0);
        add_row(mk_op(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 5, 5), 0, 0, 0);
        add_row(mk_op(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 3071, 2730), 1, 0, 1);
        add_row(mk_op(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0);
        add_row(mk_op(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 3, 3), 1, 0, 0);
        foreach (directed_rows[i])
            send_op(directed_rows[i].op, $urandom_range(0, 17),
                    directed_rows[i].typed, directed_rows[i].ans);

        // random phases, each at its own grid size
        for (int p = 0; p < RAND_PHASES; p++) begin
            drain();
            write_reg(CFG_WIDTH, phase_w[p][8:0]);
            write_reg(CFG_HEIGHT, phase_h[p][8:0]);
            if (p == 3)
                send_op(mk_op(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 1'b0, none);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 49) == 0) drain();
                send_op(random_op(), ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17),
                        1'b0, none);
            end
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("triangle_coverage_grid test passed");
        end else begin
            $display("triangle_coverage_grid test failed");
        end
        $finish;
    end
endmodule
